>>> hw/rtl/otl_pkg.sv
// otl_pkg: shared types, codes and helpers of the outstanding transaction limiter
// no dependencies; imported by every otl module
package otl_pkg;

	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RESP = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [2:0] KIND_SENT = 3'd0;
	localparam logic [2:0] KIND_UP   = 3'd1;
	localparam logic [2:0] KIND_DONE = 3'd2;
	localparam logic [2:0] KIND_PTMO = 3'd3;
	localparam logic [2:0] KIND_QTMO = 3'd4;
	localparam logic [2:0] KIND_REJ  = 3'd5;

	localparam logic [2:0] REG_MAX_OUT  = 3'd0;
	localparam logic [2:0] REG_SKIP0    = 3'd1;
	localparam logic [2:0] REG_MATCH    = 3'd2;
	localparam logic [2:0] REG_RD_TMO   = 3'd3;
	localparam logic [2:0] REG_WR_TMO   = 3'd4;

	localparam logic [7:0] WRITE_BIT = 8'h80;

	typedef struct packed {
		logic [3:0]  max_out;
		logic        skip0;
		logic        match;
		logic [15:0] rd_tmo;
		logic [15:0] wr_tmo;
	} cfg_t;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] id;
		logic [7:0]  prio;
		logic        bypass;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] id;
		logic [7:0]  prio;
		logic [31:0] lat;
		logic        last;
	} res_t;

	function automatic logic [31:0] tmo_of(input logic [7:0] prio, input cfg_t c);
		tmo_of = ((prio & WRITE_BIT) != 8'd0) ? {16'd0, c.wr_tmo} : {16'd0, c.rd_tmo};
	endfunction

endpackage

>>> hw/rtl/otl_front.sv
// otl_front: accepts input beats, classifies them and holds them in a two-entry queue
// depends on otl_pkg
module otl_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [1:0]    op,
	input  logic [15:0]   req_id,
	input  logic [7:0]    req_priority,
	input  otl_pkg::cfg_t cfg,
	output logic          cmd_valid,
	output otl_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import otl_pkg::*;

	cmd_t       q_mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cls;

	always_comb begin
		cls.op     = op;
		cls.id     = req_id;
		cls.prio   = req_priority;
		cls.bypass = (cfg.max_out == 4'd0) || (cfg.skip0 && req_id == 16'd0);
	end

	assign req_stall = (cnt_q == 2'd2);
	// op three is taken and dropped
	assign push      = req_valid && !req_stall && (op != OP_NONE);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = q_mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (cmd_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end
endmodule

>>> hw/rtl/otl_back.sv
// otl_back: sequencer over the pending table and wait store, with result hold and output register
// depends on otl_pkg
module otl_back #(
	parameter int MAX_PENDING = 8,
	parameter int WAIT_DEPTH  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  otl_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  otl_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	input  logic          res_stall,
	output otl_pkg::res_t res
);
	import otl_pkg::*;

	localparam int PIW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
	localparam int WIW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int CW  = $clog2(MAX_PENDING + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_EXEC  = 8'b0000_0010,
		ST_PSCAN = 8'b0000_0100,
		ST_RESP1 = 8'b0000_1000,
		ST_RESP2 = 8'b0001_0000,
		ST_WSCAN = 8'b0010_0000,
		ST_WEND  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	logic [31:0] now_q;
	logic [15:0] seq_q;
	logic [CW-1:0] pcnt_q;

	logic [MAX_PENDING-1:0] pv_q;
	logic [15:0] pid_q   [MAX_PENDING];
	logic [7:0]  ppr_q   [MAX_PENDING];
	logic [31:0] psent_q [MAX_PENDING];
	logic [31:0] parr_q  [MAX_PENDING];

	logic [WAIT_DEPTH-1:0] wv_q;
	logic [15:0] wid_q  [WAIT_DEPTH];
	logic [7:0]  wpr_q  [WAIT_DEPTH];
	logic [31:0] warr_q [WAIT_DEPTH];
	logic [15:0] word_q [WAIT_DEPTH];

	logic [PIW-1:0] pi_q;
	logic [WIW-1:0] wj_q;
	logic           phase_q;

	logic           hit_v_q;
	logic [PIW-1:0] hidx_q;
	logic [15:0]    hid_q;
	logic [7:0]     hpr_q;
	logic [31:0]    harr_q;
	logic [31:0]    hage_q;

	logic           bv_q;
	logic [WIW-1:0] bidx_q;
	logic [15:0]    bid_q;
	logic [7:0]     bpr_q;
	logic [31:0]    barr_q;
	logic [15:0]    ba_q;

	res_t hold_q, res_q;
	logic hold_v_q, res_valid_q;

	logic [7:0]     lim;
	logic           room;
	logic [PIW-1:0] pfree_idx;
	logic [WIW-1:0] wfree_idx;
	logic           wfree;
	logic [31:0]    p_age;
	logic           p_tmo, p_match, p_last, p_hold;
	logic [31:0]    w_age;
	logic [15:0]    w_a;
	logic           w_cand, w_better, w_last;
	logic           can_emit, out_free;
	logic           emit_en;
	logic           fin_push;
	res_t           emit_res;

	always_comb begin
		lim = {4'd0, cfg.max_out};
		if (lim > 8'(MAX_PENDING)) begin
			lim = 8'(MAX_PENDING);
		end
		if (!cfg.match && lim > 8'd1) begin
			lim = 8'd1;
		end
		room = 8'(pcnt_q) < lim;
	end

	always_comb begin
		pfree_idx = '0;
		for (int i = MAX_PENDING - 1; i >= 0; i--) begin
			if (!pv_q[i]) begin
				pfree_idx = PIW'(i);
			end
		end
		wfree_idx = '0;
		wfree     = 1'b0;
		for (int k = WAIT_DEPTH - 1; k >= 0; k--) begin
			if (!wv_q[k]) begin
				wfree_idx = WIW'(k);
				wfree     = 1'b1;
			end
		end
	end

	always_comb begin
		p_age   = now_q - psent_q[pi_q];
		p_tmo   = pv_q[pi_q] && (p_age > tmo_of(ppr_q[pi_q], cfg));
		p_match = pv_q[pi_q] && (pid_q[pi_q] == cmd_q.id) &&
			!(cfg.skip0 && cmd_q.id == 16'd0) && !hit_v_q;
		p_last  = (pi_q == PIW'(MAX_PENDING - 1));
		w_age   = now_q - warr_q[wj_q];
		w_a     = seq_q - word_q[wj_q];
		w_cand  = wv_q[wj_q] && (phase_q || (w_age >= tmo_of(wpr_q[wj_q], cfg)));
		w_better = !bv_q || (wpr_q[wj_q] > bpr_q) || (wpr_q[wj_q] == bpr_q && w_a > ba_q);
		w_last  = (wj_q == WIW'(WAIT_DEPTH - 1));
	end

	assign out_free = !res_valid_q || !res_stall;
	assign can_emit = !hold_v_q || out_free;
	assign p_hold   = (cmd_q.op == OP_TICK) && p_tmo && !can_emit;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign fin_push = (state_q == ST_FIN) && hold_v_q && out_free;

	always_comb begin
		emit_en  = 1'b0;
		emit_res = '{kind: KIND_SENT, id: cmd_q.id, prio: cmd_q.prio, lat: 32'd0, last: 1'b0};
		case (state_q)
			ST_EXEC: begin
				if (cmd_q.op == OP_SEND) begin
					emit_en = cmd_q.bypass || room || !wfree;
					if (!cmd_q.bypass && !room && !wfree) begin
						emit_res.kind = KIND_REJ;
					end
				end else if (cmd_q.op == OP_RESP && lim == 8'd0) begin
					emit_en       = 1'b1;
					emit_res.kind = KIND_UP;
					emit_res.id   = cfg.match ? cmd_q.id : 16'd0;
				end
			end
			ST_PSCAN: begin
				if (cmd_q.op == OP_TICK && p_tmo && can_emit) begin
					emit_en  = 1'b1;
					emit_res = '{kind: KIND_PTMO, id: pid_q[pi_q], prio: ppr_q[pi_q],
						lat: now_q - parr_q[pi_q], last: 1'b0};
				end
			end
			ST_RESP1: begin
				emit_en       = can_emit;
				emit_res.kind = KIND_UP;
				emit_res.id   = cfg.match ? cmd_q.id : (hit_v_q ? hid_q : 16'd0);
			end
			ST_RESP2: begin
				emit_en  = can_emit;
				emit_res = '{kind: KIND_DONE, id: hid_q, prio: hpr_q,
					lat: now_q - harr_q, last: 1'b0};
			end
			ST_WEND: begin
				emit_en  = bv_q && can_emit;
				emit_res = '{kind: phase_q ? KIND_SENT : KIND_QTMO, id: bid_q, prio: bpr_q,
					lat: phase_q ? 32'd0 : now_q - barr_q, last: 1'b0};
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// tables and captured entries
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_q <= cmd;
				end
			end
			ST_EXEC: begin
				if (cmd_q.op == OP_SEND && !cmd_q.bypass) begin
					if (room) begin
						pid_q[pfree_idx]   <= cmd_q.id;
						ppr_q[pfree_idx]   <= cmd_q.prio;
						psent_q[pfree_idx] <= now_q;
						parr_q[pfree_idx]  <= now_q;
					end else if (wfree) begin
						wid_q[wfree_idx]  <= cmd_q.id;
						wpr_q[wfree_idx]  <= cmd_q.prio;
						warr_q[wfree_idx] <= now_q;
						word_q[wfree_idx] <= seq_q;
					end
				end
			end
			ST_PSCAN: begin
				if (cmd_q.op == OP_RESP && ((cfg.match && p_match) ||
					(!cfg.match && pv_q[pi_q] && (!hit_v_q || p_age > hage_q)))) begin
					hidx_q <= pi_q;
					hid_q  <= pid_q[pi_q];
					hpr_q  <= ppr_q[pi_q];
					harr_q <= parr_q[pi_q];
					hage_q <= p_age;
				end
			end
			ST_WSCAN: begin
				if (w_cand && w_better) begin
					bidx_q <= wj_q;
					bid_q  <= wid_q[wj_q];
					bpr_q  <= wpr_q[wj_q];
					barr_q <= warr_q[wj_q];
					ba_q   <= w_a;
				end
			end
			ST_WEND: begin
				if (bv_q && can_emit && phase_q) begin
					pid_q[pfree_idx]   <= bid_q;
					ppr_q[pfree_idx]   <= bpr_q;
					psent_q[pfree_idx] <= now_q;
					parr_q[pfree_idx]  <= barr_q;
				end
			end
			default: begin
			end
		endcase
		if (emit_en) begin
			hold_q <= emit_res;
			if (hold_v_q) begin
				res_q <= hold_q;
			end
		end
		if (fin_push) begin
			res_q <= '{kind: hold_q.kind, id: hold_q.id, prio: hold_q.prio,
				lat: hold_q.lat, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= 32'd0;
			seq_q       <= 16'd0;
			pcnt_q      <= '0;
			pv_q        <= '0;
			wv_q        <= '0;
			pi_q        <= '0;
			wj_q        <= '0;
			phase_q     <= 1'b0;
			hit_v_q     <= 1'b0;
			bv_q        <= 1'b0;
			hold_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if ((emit_en && hold_v_q) || fin_push) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (emit_en) begin
				hold_v_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					pi_q    <= '0;
					hit_v_q <= 1'b0;
					case (cmd_q.op)
						OP_SEND: begin
							state_q <= ST_FIN;
							if (!cmd_q.bypass) begin
								if (room) begin
									pv_q[pfree_idx] <= 1'b1;
									pcnt_q          <= pcnt_q + 1'b1;
								end else if (wfree) begin
									wv_q[wfree_idx] <= 1'b1;
									seq_q           <= seq_q + 16'd1;
								end
							end
						end
						OP_RESP: begin
							state_q <= (lim == 8'd0) ? ST_FIN : ST_PSCAN;
						end
						OP_TICK: begin
							now_q   <= now_q + 32'd1;
							state_q <= (lim == 8'd0) ? ST_FIN : ST_PSCAN;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_PSCAN: begin
					if (cmd_q.op == OP_RESP && ((cfg.match && p_match) ||
						(!cfg.match && pv_q[pi_q] && (!hit_v_q || p_age > hage_q)))) begin
						hit_v_q <= 1'b1;
					end
					if (cmd_q.op == OP_TICK && p_tmo && can_emit) begin
						pv_q[pi_q] <= 1'b0;
						pcnt_q     <= pcnt_q - 1'b1;
					end
					if (!p_hold) begin
						if (p_last) begin
							pi_q    <= '0;
							wj_q    <= '0;
							bv_q    <= 1'b0;
							phase_q <= 1'b0;
							state_q <= (cmd_q.op == OP_RESP) ? ST_RESP1 : ST_WSCAN;
						end else begin
							pi_q <= pi_q + 1'b1;
						end
					end
				end
				ST_RESP1: begin
					if (can_emit) begin
						state_q <= hit_v_q ? ST_RESP2 : ST_FIN;
					end
				end
				ST_RESP2: begin
					if (can_emit) begin
						pv_q[hidx_q] <= 1'b0;
						pcnt_q       <= pcnt_q - 1'b1;
						state_q      <= ST_WSCAN;
					end
				end
				ST_WSCAN: begin
					if (phase_q && !room) begin
						state_q <= ST_FIN;
					end else begin
						if (w_cand && w_better) begin
							bv_q <= 1'b1;
						end
						if (w_last) begin
							state_q <= ST_WEND;
						end
						wj_q <= wj_q + 1'b1;
					end
				end
				ST_WEND: begin
					wj_q <= '0;
					if (bv_q) begin
						if (can_emit) begin
							wv_q[bidx_q] <= 1'b0;
							bv_q         <= 1'b0;
							state_q      <= ST_WSCAN;
							if (phase_q) begin
								pv_q[pfree_idx] <= 1'b1;
								pcnt_q          <= pcnt_q + 1'b1;
							end
						end
					end else if (!phase_q) begin
						phase_q <= 1'b1;
						state_q <= ST_WSCAN;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;
endmodule

>>> hw/rtl/outstanding_transaction_limiter_unit.sv
// outstanding_transaction_limiter_unit: top level, configuration registers and port mapping
// depends on otl_pkg, otl_front, otl_back
//
//   channel   handshake            payload
//   req       req_valid/req_stall  op, req_id, req_priority
//   res       res_valid/res_stall  kind, out_id, out_priority, wr_flag, latency, last
//   cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// a send needs no table walk; with a nonzero limit a response or tick walks the pending table,
// then a tick, or a response that retired an entry, scans the wait store, one scan per expired
// or issued entry plus one final scan per phase, the issue phase ending once the pending table is full
// the front queue holds two beats, so up to two inputs are taken while the sequencer is busy
// reset clears all valid bits, counters and time; no clearing pass
module outstanding_transaction_limiter_unit #(
	parameter int MAX_PENDING = 8,
	parameter int WAIT_DEPTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  op,
	input  logic [15:0] req_id,
	input  logic [7:0]  req_priority,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  kind,
	output logic [15:0] out_id,
	output logic [7:0]  out_priority,
	output logic        wr_flag,
	output logic [31:0] latency,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import otl_pkg::*;

	cfg_t cfg_q;
	logic cmd_valid, cmd_pop;
	cmd_t cmd;
	res_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{max_out: 4'd1, skip0: 1'b0, match: 1'b1, rd_tmo: 16'd200, wr_tmo: 16'd200};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_OUT: cfg_q.max_out <= cfg_data[3:0];
				REG_SKIP0:   cfg_q.skip0   <= cfg_data[0];
				REG_MATCH:   cfg_q.match   <= cfg_data[0];
				REG_RD_TMO:  cfg_q.rd_tmo  <= cfg_data;
				REG_WR_TMO:  cfg_q.wr_tmo  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	otl_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.op           (op),
		.req_id       (req_id),
		.req_priority (req_priority),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop)
	);

	otl_back #(
		.MAX_PENDING (MAX_PENDING),
		.WAIT_DEPTH  (WAIT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	assign kind         = res.kind;
	assign out_id       = res.id;
	assign out_priority = res.prio;
	assign wr_flag      = res.prio[7];
	assign latency      = res.lat;
	assign last         = res.last;
endmodule

>>> hw/rtl/otl_checker.sv
// otl_checker: port-level assertions for the limiter, bound to the top level
// depends on otl_pkg and outstanding_transaction_limiter_unit
module otl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [2:0]  kind,
	input logic [15:0] out_id,
	input logic [7:0]  out_priority,
	input logic        wr_flag,
	input logic [31:0] latency
);
	import otl_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(out_id) && $stable(kind) && $stable(latency))
		else $error("stalled result beat changed");

	a_write_bit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> wr_flag == out_priority[7])
		else $error("wr_flag does not follow priority bit 7");

	a_zero_lat: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_SENT || kind == KIND_UP || kind == KIND_REJ)
		|-> latency == 32'd0)
		else $error("latency on a kind without latency");
endmodule

bind outstanding_transaction_limiter_unit otl_checker u_otl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_stall    (res_stall),
	.kind         (kind),
	.out_id       (out_id),
	.out_priority (out_priority),
	.wr_flag      (wr_flag),
	.latency      (latency)
);

>>> test/tb_outstanding_transaction_limiter_unit.sv
// tb_outstanding_transaction_limiter_unit: self-checking bench for the outstanding transaction limiter
// depends on otl_pkg and outstanding_transaction_limiter_unit; predicts every result beat
// from its own copy of the pending table, wait store and registers, and checks them in order
module tb_outstanding_transaction_limiter_unit;
	import otl_pkg::*;

	localparam int NPEND = 8;
	localparam int NWAIT = 16;
	localparam int RES_CAP = 24;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] id;
		logic [7:0]  prio;
	} txn_t;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] id;
		logic [7:0]  prio;
		logic        wr;
		logic [31:0] lat;
		logic        last;
	} beat_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        req_valid = 0;
	logic        req_stall;
	logic [1:0]  op = OP_NONE;
	logic [15:0] req_id = 0;
	logic [7:0]  req_priority = 0;
	logic        res_valid;
	logic        res_stall = 0;
	logic [2:0]  kind;
	logic [15:0] out_id;
	logic [7:0]  out_priority;
	logic        wr_flag;
	logic [31:0] latency;
	logic        last;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_MAX_OUT;
	logic [15:0] cfg_data = 0;

	outstanding_transaction_limiter_unit DUT (.*);

	always #5 clk = ~clk;

	// predicted state
	logic [3:0]  lim_reg;
	logic        skip0_reg, match_reg;
	logic [15:0] rd_tmo_reg, wr_tmo_reg;
	logic [31:0] now_t;
	logic        p_vld [NPEND];
	logic [15:0] p_id [NPEND];
	logic [7:0]  p_prio [NPEND];
	logic [31:0] p_sent [NPEND];
	logic [31:0] p_arr [NPEND];
	logic        w_vld [NWAIT];
	logic [15:0] w_id [NWAIT];
	logic [7:0]  w_prio [NWAIT];
	logic [31:0] w_arr [NWAIT];
	logic [15:0] w_ord [NWAIT];
	logic [15:0] w_seq;

	txn_t  send_q[$];
	beat_t expected_beats[$];
	beat_t step_beats[$];
	int    errors = 0;
	bit    idle_en = 1;
	int    long_hold_req = 0;

	function automatic int eff_limit();
		int l;
		l = lim_reg;
		if (l > NPEND) l = NPEND;
		if (!match_reg && l > 1) l = 1;
		return l;
	endfunction

	function automatic logic [31:0] tmo_for(logic [7:0] p);
		return p[7] ? {16'd0, wr_tmo_reg} : {16'd0, rd_tmo_reg};
	endfunction

	function automatic int pend_count();
		int c;
		c = 0;
		for (int i = 0; i < NPEND; i++) if (p_vld[i]) c++;
		return c;
	endfunction

	function automatic void add_beat(logic [2:0] k, logic [15:0] id, logic [7:0] p,
		logic [31:0] lat);
		beat_t b;
		if (step_beats.size() >= RES_CAP) return;
		b.kind = k; b.id = id; b.prio = p; b.wr = p[7]; b.lat = lat; b.last = 0;
		step_beats.push_back(b);
	endfunction

	function automatic void track(logic [15:0] id, logic [7:0] p, logic [31:0] arr);
		for (int i = 0; i < NPEND; i++) begin
			if (!p_vld[i]) begin
				p_vld[i] = 1; p_id[i] = id; p_prio[i] = p; p_sent[i] = now_t; p_arr[i] = arr;
				return;
			end
		end
	endfunction

	// highest priority, then oldest arrival
	function automatic int pick_waiting(bit expired_only);
		int best;
		logic [7:0] bp;
		logic [15:0] ba, a;
		best = -1; bp = 0; ba = 0;
		for (int i = 0; i < NWAIT; i++) begin
			if (!w_vld[i]) continue;
			if (expired_only && (now_t - w_arr[i]) < tmo_for(w_prio[i])) continue;
			a = w_seq - w_ord[i];
			if (best < 0 || w_prio[i] > bp || (w_prio[i] == bp && a > ba)) begin
				best = i; bp = w_prio[i]; ba = a;
			end
		end
		return best;
	endfunction

	function automatic void drain_waiting(int lim);
		int b;
		b = pick_waiting(1);
		while (b >= 0) begin
			w_vld[b] = 0;
			add_beat(KIND_QTMO, w_id[b], w_prio[b], now_t - w_arr[b]);
			b = pick_waiting(1);
		end
		while (pend_count() < lim) begin
			b = pick_waiting(0);
			if (b < 0) break;
			w_vld[b] = 0;
			track(w_id[b], w_prio[b], w_arr[b]);
			add_beat(KIND_SENT, w_id[b], w_prio[b], 0);
		end
	endfunction

	function automatic void predict_txn(txn_t t);
		int lim, hit, slot;
		logic [31:0] age, best_age;
		step_beats.delete();
		lim = eff_limit();
		case (t.op)
			OP_SEND: begin
				if (lim == 0 || (skip0_reg && t.id == 0)) begin
					add_beat(KIND_SENT, t.id, t.prio, 0);
				end else if (pend_count() < lim) begin
					track(t.id, t.prio, now_t);
					add_beat(KIND_SENT, t.id, t.prio, 0);
				end else begin
					slot = -1;
					for (int i = 0; i < NWAIT; i++) if (!w_vld[i] && slot < 0) slot = i;
					if (slot >= 0) begin
						w_vld[slot] = 1; w_id[slot] = t.id; w_prio[slot] = t.prio;
						w_arr[slot] = now_t; w_ord[slot] = w_seq;
						w_seq = w_seq + 1;
					end else begin
						add_beat(KIND_REJ, t.id, t.prio, 0);
					end
				end
			end
			OP_RESP: begin
				hit = -1; best_age = 0;
				if (lim > 0) begin
					if (match_reg) begin
						if (!skip0_reg || t.id != 0)
							for (int i = 0; i < NPEND; i++)
								if (hit < 0 && p_vld[i] && p_id[i] == t.id) hit = i;
					end else begin
						for (int i = 0; i < NPEND; i++) begin
							if (!p_vld[i]) continue;
							age = now_t - p_sent[i];
							if (hit < 0 || age > best_age) begin
								hit = i; best_age = age;
							end
						end
					end
				end
				if (hit >= 0) begin
					p_vld[hit] = 0;
					add_beat(KIND_UP, match_reg ? t.id : p_id[hit], t.prio, 0);
					add_beat(KIND_DONE, p_id[hit], p_prio[hit], now_t - p_arr[hit]);
					drain_waiting(lim);
				end else begin
					add_beat(KIND_UP, match_reg ? t.id : 16'd0, t.prio, 0);
				end
			end
			OP_TICK: begin
				now_t = now_t + 1;
				if (lim > 0) begin
					for (int i = 0; i < NPEND; i++) begin
						if (p_vld[i] && (now_t - p_sent[i]) > tmo_for(p_prio[i])) begin
							p_vld[i] = 0;
							add_beat(KIND_PTMO, p_id[i], p_prio[i], now_t - p_arr[i]);
						end
					end
					drain_waiting(lim);
				end
			end
			default: ;
		endcase
		if (step_beats.size() > 0) step_beats[$].last = 1;
		foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		if (req_valid && !req_stall) begin
			predict_txn(send_q[0]);
			void'(send_q.pop_front());
		end
		if (!req_valid || !req_stall) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 0;
			end else if ((req_valid && !req_stall ? send_q.size() : send_q.size()) > 0) begin
				req_valid <= 1;
				op <= send_q[0].op;
				req_id <= send_q[0].id;
				req_priority <= send_q[0].prio;
				if (idle_en && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 5);
			end else begin
				req_valid <= 0;
			end
		end
	end

	// monitor
	int hold_left = 0;
	int holds_seen = 0;
	always @(posedge clk) begin
		beat_t e;
		if (res_valid && !res_stall) begin
			if (expected_beats.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat kind %0d id %h", $time, kind, out_id);
			end else begin
				e = expected_beats.pop_front();
				if (e.kind !== kind || e.id !== out_id || e.prio !== out_priority ||
				    e.wr !== wr_flag || e.lat !== latency || e.last !== last) begin
					errors++;
					$display("%0t: mismatch exp k%0d id %h p %h w%0d lat %0d l%0d act k%0d id %h p %h w%0d lat %0d l%0d",
						$time, e.kind, e.id, e.prio, e.wr, e.lat, e.last,
						kind, out_id, out_priority, wr_flag, latency, last);
				end
			end
		end
		if (holds_seen != long_hold_req) begin
			holds_seen = long_hold_req;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			hold_left = $urandom_range(0, 4);
			res_stall <= 1;
		end else begin
			res_stall <= 0;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAX_OUT: lim_reg = val[3:0];
			REG_SKIP0:   skip0_reg = val[0];
			REG_MATCH:   match_reg = val[0];
			REG_RD_TMO:  rd_tmo_reg = val;
			REG_WR_TMO:  wr_tmo_reg = val;
			default: ;
		endcase
		cfg_valid <= 0;
	endtask

	task automatic put(logic [1:0] o, logic [15:0] id, logic [7:0] p);
		txn_t t;
		t.op = o; t.id = id; t.prio = p;
		send_q.push_back(t);
	endtask

	task automatic settle();
		while (send_q.size() > 0 || expected_beats.size() > 0 || req_valid) @(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	task automatic configure(logic [3:0] lim, bit s0, bit m, logic [15:0] rd, logic [15:0] wr);
		write_reg(REG_MAX_OUT, {12'd0, lim});
		write_reg(REG_SKIP0, {15'd0, s0});
		write_reg(REG_MATCH, {15'd0, m});
		write_reg(REG_RD_TMO, rd);
		write_reg(REG_WR_TMO, wr);
	endtask

	task automatic random_txns(int n);
		int r;
		logic [15:0] id;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
			if (r < 42) put(OP_SEND, id, 8'($urandom));
			else if (r < 70) put(OP_RESP, id, 8'($urandom));
			else if (r < 96) put(OP_TICK, 16'($urandom), 8'($urandom));
			else put(OP_NONE, 16'($urandom), 8'($urandom));
		end
	endtask

	initial begin
		lim_reg = 1; skip0_reg = 0; match_reg = 1; rd_tmo_reg = 200; wr_tmo_reg = 200;
		now_t = 0; w_seq = 0;
		for (int i = 0; i < NPEND; i++) p_vld[i] = 0;
		for (int i = 0; i < NWAIT; i++) w_vld[i] = 0;
		repeat (7) @(posedge clk);
		arst_n = 1;

		// reset settings: fill the store, reject, retire, idle op
		put(OP_SEND, 16'h0000, 8'h00);
		put(OP_SEND, 16'hFFFF, 8'hFF);
		for (int i = 0; i < 15; i++) put(OP_SEND, 16'(i + 1), 8'(i * 17));
		put(OP_SEND, 16'h5555, 8'h80);
		put(OP_RESP, 16'h0000, 8'h80);
		put(OP_RESP, 16'h1234, 8'h7F);
		put(OP_NONE, 16'hFFFF, 8'hFF);
		put(OP_TICK, 16'hAAAA, 8'h00);
		settle();

		// zero read timeout, max write timeout, id zero bypass, oldest match
		configure(4'd2, 1, 0, 16'd0, 16'hFFFF);
		put(OP_SEND, 16'h0000, 8'h01);
		put(OP_SEND, 16'h0005, 8'h10);
		put(OP_SEND, 16'h0006, 8'h90);
		put(OP_TICK, 16'h0000, 8'h00);
		put(OP_RESP, 16'h0009, 8'h00);
		put(OP_TICK, 16'h0000, 8'h00);
		settle();

		configure(4'd0, 0, 1, 16'd5, 16'd5);
		put(OP_SEND, 16'h0007, 8'h00);
		put(OP_RESP, 16'h0007, 8'h00);
		put(OP_TICK, 16'h0000, 8'h00);
		settle();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: configure(4'd8, 0, 1, 16'd3, 16'd6);
				1: configure(4'd15, 1, 1, 16'd2, 16'd0);
				2: configure(4'd1, 0, 1, 16'd4, 16'd4);
				3: configure(4'd3, 1, 0, 16'd1, 16'd8);
				4: configure(4'($urandom_range(0, 15)), 1'($urandom), 1'($urandom),
					16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)));
				5: configure(4'd4, 0, 1, 16'hFFFF, 16'd3);
				default: configure(4'd2, 0, 1, 16'd2, 16'd5);
			endcase
			if (ph == 2) long_hold_req++;
			if (ph == 6) idle_en = 0;
			random_txns(30);
			settle();
		end

		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/otl_pkg.sv
hw/rtl/otl_front.sv
hw/rtl/otl_back.sv
hw/rtl/outstanding_transaction_limiter_unit.sv
hw/rtl/otl_checker.sv
test/tb_outstanding_transaction_limiter_unit.sv
